### src/mtbr_pkg.sv
// ============================================================================
// mtbr_pkg
// Shared constants, types and the tempering function for the bounded
// MT19937 random source.
// ============================================================================
package mtbr_pkg;

    // Twister geometry
    localparam int unsigned TW_N      = 624;
    localparam int unsigned TW_M      = 397;
    localparam int unsigned TW_IDX_W  = 10;
    localparam int unsigned WORD_W    = 32;

    // Divider step counter width
    localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

    localparam logic [TW_IDX_W-1:0] TW_LAST     = TW_IDX_W'(TW_N - 1);
    localparam logic [TW_IDX_W-1:0] TW_END      = TW_IDX_W'(TW_N);
    localparam logic [TW_IDX_W-1:0] TW_OFS_FWD  = TW_IDX_W'(TW_M);
    localparam logic [TW_IDX_W-1:0] TW_OFS_BACK = TW_IDX_W'(TW_N - TW_M);

    // Recurrence and seeding constants
    localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TW_INIT_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    // Tempering masks
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;

    // Commands into the twister state unit
    typedef struct packed {
        logic fill;   // restart seeding from the seed word
        logic req;    // fetch the next word
    } tw_ctrl_t;

    // Status from the twister state unit
    typedef struct packed {
        logic ready;       // idle, can take a request
        logic word_valid;  // word output holds the fetched word this cycle
    } tw_stat_t;

    // Standard four-step tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

### src/mtbr_twister.sv
// ============================================================================
// mtbr_twister
// 624-word twister state RAM with its seeding sequencer, the in-place
// regeneration sequencer and the word read path.
// ============================================================================
module mtbr_twister
    import mtbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tw_ctrl_t          ctrl,
    input  logic [WORD_W-1:0] seed,
    output tw_stat_t          stat,
    output logic [WORD_W-1:0] word
);

    typedef enum logic [7:0] {
        TW_SEED     = 8'b0000_0001,
        TW_FILL     = 8'b0000_0010,
        TW_IDLE     = 8'b0000_0100,
        TW_REGEN_LD = 8'b0000_1000,
        TW_REGEN_RD = 8'b0001_0000,
        TW_REGEN_WR = 8'b0010_0000,
        TW_READ     = 8'b0100_0000,
        TW_READ_WT  = 8'b1000_0000
    } tw_state_t;

    tw_state_t state_reg, state_next;
    logic [TW_IDX_W-1:0] pos_reg, pos_next;
    logic [TW_IDX_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0]   prev_reg, prev_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;

    // State memory, one write and two read ports, registered reads
    logic [WORD_W-1:0]   twister_mem [0:TW_N-1];
    logic [WORD_W-1:0]   rd_a_reg, rd_b_reg;
    logic [TW_IDX_W-1:0] raddr_a, raddr_b;
    logic                we;
    logic [TW_IDX_W-1:0] waddr;
    logic [WORD_W-1:0]   wdata;

    // Datapath terms
    logic [WORD_W-1:0]   fill_x, fill_val;
    logic [WORD_W-1:0]   regen_y, regen_val;
    logic [TW_IDX_W-1:0] idx_nxt, idx_far;

    // Seeding step: mult * (prev ^ prev >> 30) + i, low 32 bits
    assign fill_x   = prev_reg ^ (prev_reg >> 30);
    assign fill_val = TW_INIT_MULT * fill_x + {{(WORD_W-TW_IDX_W){1'b0}}, idx_reg};

    // Twist of word k, using cur (old word k), port a (word k+1), port b (far word)
    assign regen_y   = {cur_reg[WORD_W-1], rd_a_reg[WORD_W-2:0]};
    assign regen_val = rd_b_reg ^ (regen_y >> 1) ^ (regen_y[0] ? TW_MATRIX : '0);

    // Neighbor and far indexes with wrap
    assign idx_nxt = (idx_reg == TW_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_far = (idx_reg < TW_OFS_BACK) ? idx_reg + TW_OFS_FWD
                                             : idx_reg - TW_OFS_BACK;

    // Read addresses
    always_comb
    begin
        if (state_reg == TW_REGEN_RD)
        begin
            raddr_a = idx_nxt;
        end
        else if (pos_reg == TW_END)
        begin
            raddr_a = '0;
        end
        else
        begin
            raddr_a = pos_reg;
        end
        raddr_b = idx_far;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = fill_val;

        unique case (state_reg)
            TW_SEED:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = seed;
                prev_next  = seed;
                idx_next   = TW_IDX_W'(1);
                pos_next   = TW_END;
                state_next = TW_FILL;
            end
            TW_FILL:
            begin
                we        = 1'b1;
                prev_next = fill_val;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == TW_LAST)
                begin
                    state_next = TW_IDLE;
                end
            end
            TW_IDLE:
            begin
                if (ctrl.req)
                begin
                    state_next = (pos_reg == TW_END) ? TW_REGEN_LD : TW_READ_WT;
                end
            end
            TW_REGEN_LD:
            begin
                cur_next   = rd_a_reg;
                idx_next   = '0;
                state_next = TW_REGEN_RD;
            end
            TW_REGEN_RD:
            begin
                state_next = TW_REGEN_WR;
            end
            TW_REGEN_WR:
            begin
                we       = 1'b1;
                wdata    = regen_val;
                cur_next = rd_a_reg;
                if (idx_reg == TW_LAST)
                begin
                    pos_next   = '0;
                    state_next = TW_READ;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = TW_REGEN_RD;
                end
            end
            TW_READ:
            begin
                state_next = TW_READ_WT;
            end
            TW_READ_WT:
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = TW_IDLE;
            end
            default:
            begin
                state_next = TW_SEED;
            end
        endcase

        // Reseed overrides whatever is in flight
        if (ctrl.fill)
        begin
            we         = 1'b0;
            state_next = TW_SEED;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TW_SEED;
            pos_reg   <= TW_END;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
    end

    // State memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            twister_mem[waddr] <= wdata;
        end
        rd_a_reg <= twister_mem[raddr_a];
        rd_b_reg <= twister_mem[raddr_b];
    end

    assign stat.ready      = (state_reg == TW_IDLE);
    assign stat.word_valid = (state_reg == TW_READ_WT);
    assign word            = rd_a_reg;

endmodule

### src/mtbr_divider.sv
// ============================================================================
// mtbr_divider
// Restoring radix-2 divider returning the remainder, one quotient bit per
// cycle while busy.
// ============================================================================
module mtbr_divider
    import mtbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;

    logic [WORD_W:0]      trial;
    logic                 fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? WORD_W'(trial - {1'b0, dvs_reg}) : trial[WORD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### src/mt19937_bounded_random.sv
// ============================================================================
// mt19937_bounded_random
// Bounded random source: next tempered MT19937 word reduced modulo the
// requested limit (raw word for a zero limit).
// ============================================================================
//
//  Channel   Direction  Signals                          Payload
//  s_*       in         s_tvalid s_tready s_tdata[31:0]  limit
//  m_*       out        m_tvalid m_tready m_tdata[31:0]  value
//  cfg_*     in         cfg_valid cfg_ready cfg_data     seed word
//
//  Requests are taken one at a time; one with a nonzero limit passes
//  through the remainder divider, one with a zero limit skips it.
//  The first request after seeding, and every 624th after it, first
//  regenerates the state, word by word through a read and a write state,
//  as set by the state RAM read and write ports.
//  After reset, and after each seed write, seeding fills all 624 words with
//  s_tready low; cfg_ready is always high.
//  A finished result waits in the output register while the next request
//  is accepted; a stalled m_tready holds only the following result.
//
module mt19937_bounded_random
    import mtbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request: limit
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,    // [31:0] limit
    // result: value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,    // [31:0] value
    // seed write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WORD   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] limit_reg, limit_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0] m_tdata_reg, m_tdata_next;

    tw_ctrl_t          tw_ctrl;
    tw_stat_t          tw_stat;
    logic [WORD_W-1:0] tw_word;
    logic [WORD_W-1:0] tempered;

    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;

    logic              in_xact;
    logic              cfg_xact;

    assign cfg_ready = 1'b1;
    assign cfg_xact  = cfg_valid & cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE) & tw_stat.ready;
    assign in_xact   = s_tvalid & s_tready;

    assign tempered = temper(tw_word);

    // Twister state unit
    assign tw_ctrl.fill = cfg_xact;
    assign tw_ctrl.req  = in_xact;

    mtbr_twister u_twister (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tw_ctrl),
        .seed  (seed_reg),
        .stat  (tw_stat),
        .word  (tw_word)
    );

    // Remainder unit
    mtbr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tempered),
        .divisor   (limit_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Request sequencer and output register
    always_comb
    begin
        state_next    = state_reg;
        seed_next     = seed_reg;
        limit_next    = limit_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;

        if (cfg_xact)
        begin
            seed_next = cfg_data;
        end

        // Output transaction frees the register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    limit_next = s_tdata;
                    state_next = ST_WORD;
                end
            end
            ST_WORD:
            begin
                if (tw_stat.word_valid)
                begin
                    if (limit_reg == '0)
                    begin
                        res_next   = tempered;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next   = div_rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seed_reg     <= SEED_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        limit_reg   <= limit_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sim/mt19937_bounded_random_test.sv
`timescale 1ns / 100ps
// ============================================================================
// mt19937_bounded_random_test
// Self-checking bench for the bounded MT19937 source. A directed table of
// limits runs first, then random limits over several seeds and idle
// patterns. Every result is checked against a local twister model or a typed-in value.
// ============================================================================
module mt19937_bounded_random_test;
    import mtbr_pkg::*;

    // Local twister constants, kept apart from the design's own copies
    localparam int unsigned    MT_SIZE      = 624;
    localparam int unsigned    MT_SHIFT     = 397;
    localparam logic [31:0]    MT_XOR_A     = 32'h9908_b0df;
    localparam logic [31:0]    MT_SEED_MULT = 32'd1812433253;
    localparam logic [31:0]    MT_MASK_B    = 32'h9d2c_5680;
    localparam logic [31:0]    MT_MASK_C    = 32'hefc6_0000;
    localparam logic [31:0]    SEED_DEFAULT = 32'd5489;
    localparam int unsigned    CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned    TAIL_CYCLES  = 60;

    typedef enum int {IDLE_SEND_SPARSE, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct {
        logic [31:0] limit;
        bit          known;   // value typed in below
        logic [31:0] value;
    } limit_row_t;

    // Directed limits: first words after reset, unit and extreme limits
    localparam int DIR_ROWS = 18;
    limit_row_t limit_rows [DIR_ROWS] = '{
        '{32'h0000_0000, 1'b1, 32'd3499211612},  // first word for the default seed
        '{32'h0000_0000, 1'b1, 32'd581869302},   // second word, still raw
        '{32'h0000_0001, 1'b1, 32'd0},
        '{32'h0000_0002, 1'b0, 32'd0},
        '{32'h0000_0003, 1'b0, 32'd0},
        '{32'hffff_ffff, 1'b0, 32'd0},
        '{32'hffff_fffe, 1'b0, 32'd0},
        '{32'h8000_0000, 1'b0, 32'd0},
        '{32'h7fff_ffff, 1'b0, 32'd0},
        '{32'h8000_0001, 1'b0, 32'd0},
        '{32'h0000_0000, 1'b0, 32'd0},
        '{32'h0000_000a, 1'b0, 32'd0},
        '{32'h0001_0000, 1'b0, 32'd0},
        '{32'h5555_5555, 1'b0, 32'd0},
        '{32'haaaa_aaaa, 1'b0, 32'd0},
        '{32'h0000_0001, 1'b1, 32'd0},
        '{32'h0000_0007, 1'b0, 32'd0},
        '{32'h0000_0000, 1'b0, 32'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata;    // [31:0] limit
    logic              m_tvalid;
    logic              m_tready;
    logic [WORD_W-1:0] m_tdata;    // [31:0] value
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data;

    // Twister model state
    logic [31:0]  mt_words [MT_SIZE];
    int unsigned  mt_pos;

    logic [31:0]  pending_values [$];
    logic [31:0]  want_value;
    int unsigned  send_gap_pct;
    int unsigned  recv_stall_pct;
    int unsigned  error_count;
    int unsigned  requests_sent;
    int unsigned  zero_limits;
    int unsigned  results_checked;
    int unsigned  regen_count;
    int unsigned  seed_writes;
    int unsigned  cycle_count;

    mt19937_bounded_random u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Standard seeding; the position is left at the end to force a twist
    function automatic void mt_load_seed(input logic [31:0] seed_word);
        logic [31:0] prev;
        mt_words[0] = seed_word;
        for (int i = 1; i < MT_SIZE; i++)
        begin
            prev        = mt_words[i-1];
            mt_words[i] = MT_SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
        mt_pos = MT_SIZE;
    endfunction

    // Regenerate all words in place
    function automatic void mt_twist();
        logic [31:0] joined;
        for (int k = 0; k < MT_SIZE; k++)
        begin
            joined      = {mt_words[k][31], mt_words[(k + 1) % MT_SIZE][30:0]};
            mt_words[k] = mt_words[(k + MT_SHIFT) % MT_SIZE] ^ (joined >> 1)
                        ^ (joined[0] ? MT_XOR_A : 32'h0);
        end
        mt_pos = 0;
        regen_count++;
    endfunction

    function automatic logic [31:0] mt_tempered(input logic [31:0] raw);
        logic [31:0] t1, t2, t3;
        t1 = raw ^ (raw >> 11);
        t2 = t1 ^ ((t1 << 7) & MT_MASK_B);
        t3 = t2 ^ ((t2 << 15) & MT_MASK_C);
        return t3 ^ (t3 >> 18);
    endfunction

    // Next word from the model, reduced by the limit (raw for zero)
    function automatic logic [31:0] next_bounded_value(input logic [31:0] lim);
        logic [31:0] word;
        if (mt_pos >= MT_SIZE)
            mt_twist();
        word = mt_tempered(mt_words[mt_pos]);
        mt_pos++;
        return (lim == 32'h0) ? word : word % lim;
    endfunction

    // Mix of zero, small, power-of-two, near-max and full-range limits
    function automatic logic [31:0] random_limit();
        case ($urandom_range(9))
            0, 1:    return 32'h0;
            2, 3:    return 32'($urandom_range(16, 1));
            4:       return 32'h1 << $urandom_range(31);
            5:       return 32'hffff_ffff - 32'($urandom_range(3));
            default: return $urandom();
        endcase
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND_SPARSE:
            begin
                send_gap_pct   = 33;
                recv_stall_pct = 77;
            end
            IDLE_SEND_HEAVY:
            begin
                send_gap_pct   = 77;
                recv_stall_pct = 33;
            end
            default:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // One request transaction; entered and left at a rising edge
    task automatic send_limit(input logic [31:0] lim, input bit known,
                              input logic [31:0] known_value);
        logic [31:0] model_value;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lim;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        model_value = next_bounded_value(lim);
        pending_values.push_back(known ? known_value : model_value);
        requests_sent++;
        if (lim == 32'h0)
            zero_limits++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_limit(random_limit(), 1'b0, 32'h0);
    endtask

    // Let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    // Seed write transaction; only issued with nothing outstanding
    task automatic write_seed(input logic [31:0] seed_word);
        cfg_valid <= 1'b1;
        cfg_data  <= seed_word;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        mt_load_seed(seed_word);
        seed_writes++;
    endtask

    // Result side: random backpressure, driven at the rising edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check, sampled mid-cycle where everything is stable
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (pending_values.size() == 0)
            begin
                $error("value: expected none, actual %0d", m_tdata);
                error_count++;
            end
            else
            begin
                want_value = pending_values.pop_front();
                if (m_tdata !== want_value)
                begin
                    $error("value: expected %0d, actual %0d", want_value, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("mt19937_bounded_random test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        error_count     = 0;
        requests_sent   = 0;
        zero_limits     = 0;
        results_checked = 0;
        regen_count     = 0;
        seed_writes     = 0;
        set_idle(IDLE_SEND_SPARSE);
        mt_load_seed(SEED_DEFAULT);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default seed: directed rows, then enough to cross one regeneration
        for (int r = 0; r < DIR_ROWS; r++)
            send_limit(limit_rows[r].limit, limit_rows[r].known, limit_rows[r].value);
        send_random(620);
        drain();

        // Extreme and random seeds under the sparse and heavy idle patterns
        write_seed(32'h0000_0000);
        send_random(150);
        drain();

        set_idle(IDLE_SEND_HEAVY);
        write_seed(32'hffff_ffff);
        send_random(150);
        drain();

        write_seed($urandom());
        send_random(150);
        drain();

        // Full rate, long enough for a second regeneration
        set_idle(IDLE_NONE);
        write_seed(32'h0000_0001);
        send_random(680);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_values.size() != 0)
        begin
            $error("value: %0d results never arrived", pending_values.size());
            error_count++;
        end

        $display("Run covered %0d requests (%0d zero limits) over %0d seed writes",
                 requests_sent, zero_limits, seed_writes);
        $display("%0d results checked, %0d state regenerations, %0d errors",
                 results_checked, regen_count, error_count);
        if (error_count == 0)
            $display("mt19937_bounded_random test passed");
        else
            $display("mt19937_bounded_random test failed");
        $finish;
    end

endmodule

### sim.f
src/mtbr_pkg.sv
src/mtbr_twister.sv
src/mtbr_divider.sv
src/mt19937_bounded_random.sv
sim/mt19937_bounded_random_test.sv
